>>> sv/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared sizes, request codes and controller states of the list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int LEN_W       = $clog2(CAPACITY + 1);
  localparam int WIDE_W      = (LEN_W > 7) ? LEN_W : 7;
  localparam int CMP_W       = WIDE_W + 1;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 7;
  localparam int FUNC_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_READ   = 3'd2,
    FN_LOCATE = 3'd3,
    FN_SORTED = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT_UP,
    ST_FINISH
  } state_t;

  // length-sized value to the 7-bit result fields (masked or zero-extended)
  function automatic logic [POS_W-1:0] fit_pos(input logic [LEN_W-1:0] v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/sequential_list_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// Bounded ordered list of signed words held in one synchronous RAM.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A read fetches its one
// element; insert at position p shifts the elements from the end down
// to p up by one, and writes directly when appending at the end; delete
// at p walks from p to the end, moving each later element down; locate
// walks until a match or the end of the list; sorted insert scans to its
// slot and then shifts, and writes directly on an empty list. A rejected
// request answers without touching the RAM. The element RAM has a
// single registered read port that walks one element per cycle. The
// engine returns to idle as the result is loaded into the output
// register; a stalled output adds its stall only when an earlier result
// still occupies the output register. No clearing pass after reset:
// entries at or beyond the length are never read. A new request is taken
// while a finished result still waits on the output.
// ----------------------------------------------------------------------------
module sequential_list_engine_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [sle_pkg::IN_TDATA_W-1:0] in_tdata,  // position[6:0], value_in[38:7], pad
  input  wire logic [sle_pkg::FUNC_W-1:0]     in_tuser,  // func[2:0]
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sle_pkg::OUT_TDATA_W-1:0]     out_tdata, // value_out[31:0], found_position[38:32],
                                                         // count[45:39], is_empty[46], pad
  output logic                                out_tuser  // ok
);
  import sle_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              pend_r, pend_nxt;
  logic              rd_done_r, rd_done_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  func_t             func_r, func_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic [LEN_W-1:0]  res_pos_r, res_pos_nxt;

  logic              out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic              in_fire;
  func_t             in_func;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic [CMP_W-1:0]  posx, lenx;
  logic [IDX_W-1:0]  in_idx, len_m1, sort_k;
  logic              not_full, ins_ok, acc_ok;
  logic              hit, walk_end, up_end, out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_func    = func_t'(in_tuser);
  assign in_pos     = in_tdata[POS_W-1:0];
  assign in_val     = in_tdata[POS_W+DATA_W-1:POS_W];

  assign posx       = CMP_W'(in_pos);
  assign lenx       = CMP_W'(len_r);
  assign not_full   = (len_r < LEN_W'(CAPACITY));
  assign ins_ok     = (in_pos != '0) && (posx <= lenx + CMP_W'(1)) && not_full;
  assign acc_ok     = (in_pos != '0) && (posx <= lenx);
  assign in_idx     = IDX_W'(posx - CMP_W'(1));
  assign len_m1     = IDX_W'(lenx - CMP_W'(1));

  assign hit        = pend_r &&
                      (((func_r == FN_LOCATE) && (rd_data_r == val_r)) ||
                       ((func_r == FN_SORTED) &&
                        !($signed(rd_data_r) < $signed(val_r))));
  assign walk_end   = hit || (rd_done_r && !pend_r);
  assign up_end     = rd_done_r && !pend_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign sort_k     = hit ? src_r : IDX_W'(len_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {1'b0, out_empty_r, out_cnt_r, out_pos_r, out_val_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_INSERT: state_nxt = ins_ok ? ST_SHIFT_UP : ST_FINISH;
            FN_DELETE,
            FN_READ:   state_nxt = acc_ok ? ST_WALK : ST_FINISH;
            FN_LOCATE: state_nxt = (len_r != '0) ? ST_WALK : ST_FINISH;
            FN_SORTED: begin
              if (!not_full) state_nxt = ST_FINISH;
              else if (len_r != '0) state_nxt = ST_WALK;
              else state_nxt = ST_SHIFT_UP;
            end
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_end) state_nxt = (func_r == FN_SORTED) ? ST_SHIFT_UP : ST_FINISH;
      end
      ST_SHIFT_UP: begin
        if (up_end) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_nxt        = len_r;
    pend_nxt       = pend_r;
    rd_done_nxt    = rd_done_r;
    func_nxt       = func_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    addr_nxt       = addr_r;
    src_nxt        = src_r;
    last_nxt       = last_r;
    res_ok_nxt     = res_ok_r;
    res_val_nxt    = res_val_r;
    res_pos_nxt    = res_pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_ok_nxt     = out_ok_r;
    out_val_nxt    = out_val_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = val_r;
    mem_ra         = addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_func;
          val_nxt     = in_val;
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          res_pos_nxt = '0;
          pend_nxt    = 1'b0;
          rd_done_nxt = 1'b0;
          idx_nxt     = in_idx;
          addr_nxt    = '0;
          last_nxt    = len_m1;
          case (in_func)
            FN_INSERT: begin
              res_ok_nxt  = ins_ok;
              addr_nxt    = len_m1;
              rd_done_nxt = (lenx == posx - CMP_W'(1));
            end
            FN_DELETE: begin
              res_ok_nxt = acc_ok;
              addr_nxt   = in_idx;
            end
            FN_READ: begin
              res_ok_nxt = acc_ok;
              addr_nxt   = in_idx;
              last_nxt   = in_idx;
            end
            FN_SORTED: begin
              res_ok_nxt = not_full;
              if (len_r == '0) begin
                idx_nxt     = '0;
                rd_done_nxt = 1'b1;
                res_pos_nxt = LEN_W'(1);
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        if (!rd_done_r) begin
          src_nxt     = addr_r;
          addr_nxt    = addr_r + 1'b1;
          rd_done_nxt = (addr_r == last_r);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          case (func_r)
            FN_DELETE: begin
              if (src_r == idx_r) begin
                res_val_nxt = rd_data_r;
              end else begin
                mem_we = 1'b1;
                mem_wa = src_r - 1'b1;
                mem_wd = rd_data_r;
              end
            end
            FN_READ:   res_val_nxt = rd_data_r;
            FN_LOCATE: begin
              if (hit) begin
                res_ok_nxt  = 1'b1;
                res_pos_nxt = LEN_W'(src_r) + LEN_W'(1);
              end
            end
            default: ;
          endcase
        end
        if (walk_end) begin
          if (func_r == FN_DELETE) len_nxt = len_r - 1'b1;
          if (func_r == FN_SORTED) begin
            idx_nxt     = sort_k;
            res_pos_nxt = LEN_W'(sort_k) + LEN_W'(1);
            addr_nxt    = IDX_W'(len_r - 1'b1);
            rd_done_nxt = !hit;
            pend_nxt    = 1'b0;
          end
        end
      end

      ST_SHIFT_UP: begin
        if (!rd_done_r) begin
          src_nxt     = addr_r;
          addr_nxt    = addr_r - 1'b1;
          rd_done_nxt = (addr_r == idx_r);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = src_r + 1'b1;
          mem_wd = rd_data_r;
        end
        if (up_end) begin
          mem_we  = 1'b1;
          mem_wa  = idx_r;
          mem_wd  = val_r;
          len_nxt = len_r + 1'b1;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ok_nxt     = res_ok_r;
          out_val_nxt    = res_val_r;
          out_pos_nxt    = fit_pos(res_pos_r);
          out_cnt_nxt    = fit_pos(len_r);
          out_empty_nxt  = (len_r == '0);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      len_r        <= '0;
      pend_r       <= 1'b0;
      rd_done_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      pend_r       <= pend_nxt;
      rd_done_r    <= rd_done_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    addr_r      <= addr_nxt;
    src_r       <= src_nxt;
    last_r      <= last_nxt;
    res_ok_r    <= res_ok_nxt;
    res_val_r   <= res_val_nxt;
    res_pos_r   <= res_pos_nxt;
    out_ok_r    <= out_ok_nxt;
    out_val_r   <= out_val_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule
`default_nettype wire

>>> test/tb_sequential_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine_top
// Self-checking bench for the bounded ordered list engine.
// ----------------------------------------------------------------------------
// A short table of directed requests hits the empty list, the signed extremes,
// the length+1 boundary for read and delete, failed locates and unused codes.
// Random requests then swing the list between empty and full, with values
// often drawn from the list itself so that locates hit. Every accepted
// request runs through a local list model; results are compared field by
// field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine_top;
  import sle_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7fff_ffff;
  localparam int                RANDOM_REQS = 800;
  localparam int                DRAIN_WAIT  = 100;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  fpos;
    logic [POS_W-1:0]  count;
    logic              empty;
  } list_result_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                typed;
    list_result_t      want;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len;
  list_result_t      list_results_q[$];
  script_row_t       script[$];
  list_result_t      got;
  list_result_t      want_now;
  bit                quiet;
  bit                filling;
  int                errors;
  int                checked;
  int                op_count [8];
  int                full_rejects;
  int                times_full;
  int                times_emptied;
  int                stall_left;

  sequential_list_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly no gap, else mostly short gaps and a few long ones, none during quiet stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void place_at(input int idx, input logic [DATA_W-1:0] v);
    int j;
    for (j = list_len; j > idx; j--) list_mem[j] = list_mem[j-1];
    list_mem[idx] = v;
    list_len++;
  endfunction

  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] fn,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] val);
    list_result_t r;
    int           k;
    bit           hit;
    r = '0;
    case (fn)
      FN_INSERT: begin
        if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
          place_at(pos - 1, val);
          r.ok = 1'b1;
        end
      end
      FN_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          r.value = list_mem[pos-1];
          for (k = pos - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      FN_READ: begin
        if (pos >= 1 && pos <= list_len) begin
          r.value = list_mem[pos-1];
          r.ok    = 1'b1;
        end
      end
      FN_LOCATE: begin
        hit = 1'b0;
        for (k = 0; k < list_len && !hit; k++) begin
          if (list_mem[k] == val) begin
            hit    = 1'b1;
            r.ok   = 1'b1;
            r.fpos = POS_W'(k + 1);
          end
        end
      end
      FN_SORTED: begin
        if (list_len < CAPACITY) begin
          k = 0;
          while (k < list_len && $signed(list_mem[k]) < $signed(val)) k++;
          place_at(k, val);
          r.ok   = 1'b1;
          r.fpos = POS_W'(k + 1);
        end
      end
      default: ;
    endcase
    r.count = POS_W'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] seen,
                                 input logic [DATA_W-1:0] wanted);
    $display("mismatch %s: got %0h, want %0h at %0t", field, seen, wanted, $realtime);
    errors++;
  endtask

  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input bit typed,
                              input list_result_t want);
    int           gap;
    int           len_before;
    list_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      if (in_tvalid) in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    len_before = list_len;
    pred = apply_list_op(fn, pos, val);
    list_results_q.push_back(typed ? want : pred);
    op_count[fn]++;
    if ((fn == FN_INSERT || fn == FN_SORTED) && len_before == CAPACITY) full_rejects++;
    if (list_len == CAPACITY && len_before != CAPACITY) times_full++;
    if (list_len == 0 && len_before != 0) times_emptied++;
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val, input bit typed, input logic ok,
                         input logic [DATA_W-1:0] value, input int fpos, input int count);
    script_row_t row;
    row.fn         = fn;
    row.pos        = pos;
    row.val        = val;
    row.typed      = typed;
    row.want.ok    = ok;
    row.want.value = value;
    row.want.fpos  = POS_W'(fpos);
    row.want.count = POS_W'(count);
    row.want.empty = (count == 0);
    script.push_back(row);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int hit_pct);
    logic [DATA_W-1:0] pool [7];
    int                roll;
    pool = '{VAL_MIN, VAL_MAX, 32'hffff_ffff, 32'd0, 32'd1, 32'd2, 32'hffff_fffe};
    roll = $urandom_range(0, 99);
    if (list_len > 0 && roll < hit_pct) return list_mem[$urandom_range(0, list_len - 1)];
    if (roll < hit_pct + 20) return pool[$urandom_range(0, 6)];
    return $urandom;
  endfunction

  task automatic send_random();
    int                roll;
    int                ins_w;
    int                del_w;
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    if (list_len == CAPACITY) filling = 1'b0;
    if (list_len == 0)        filling = 1'b1;
    ins_w = filling ? 40 : 12;
    del_w = filling ? 10 : 38;
    roll  = $urandom_range(0, 99);
    if (roll < 3)                         fn = 3'(FN_UNUSED_5 + $urandom_range(0, 2));
    else if (roll < 3 + ins_w)            fn = FN_INSERT;
    else if (roll < 3 + ins_w + del_w)    fn = FN_DELETE;
    else if (roll < 3 + ins_w + del_w + 12) fn = FN_READ;
    else if (roll < 3 + ins_w + del_w + 27) fn = FN_LOCATE;
    else                                  fn = FN_SORTED;
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(1, list_len + 1));
    else                            pos = POS_W'($urandom_range(0, 65));
    val = pick_value(fn == FN_LOCATE ? 60 : 15);
    send_request(fn, pos, val, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.ok    = out_tuser;
      got.value = out_tdata[31:0];
      got.fpos  = out_tdata[38:32];
      got.count = out_tdata[45:39];
      got.empty = out_tdata[46];
      if (list_results_q.size() == 0) begin
        report_mismatch("unexpected result", got.value, '0);
      end else begin
        want_now = list_results_q.pop_front();
        checked++;
        if (got.ok !== want_now.ok) report_mismatch("ok", 32'(got.ok), 32'(want_now.ok));
        if (got.value !== want_now.value) report_mismatch("value_out", got.value, want_now.value);
        if (got.fpos !== want_now.fpos)
          report_mismatch("found_position", 32'(got.fpos), 32'(want_now.fpos));
        if (got.count !== want_now.count)
          report_mismatch("count", 32'(got.count), 32'(want_now.count));
        if (got.empty !== want_now.empty)
          report_mismatch("is_empty", 32'(got.empty), 32'(want_now.empty));
      end
    end
  end

  initial begin
    int i;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    stall_left    = 0;
    quiet         = 1'b0;
    filling       = 1'b1;
    list_len      = 0;
    errors        = 0;
    checked       = 0;
    full_rejects  = 0;
    times_full    = 0;
    times_emptied = 0;
    foreach (op_count[k]) op_count[k] = 0;

    // fn, pos, value, typed, ok, value_out, found_position, count
    add_row(FN_READ,     7'd1,  32'd0,       1, 0, 32'd0,   0, 0);
    add_row(FN_DELETE,   7'd1,  32'd0,       1, 0, 32'd0,   0, 0);
    add_row(FN_INSERT,   7'd0,  32'd5,       1, 0, 32'd0,   0, 0);
    add_row(FN_INSERT,   7'd2,  32'd5,       1, 0, 32'd0,   0, 0);
    add_row(FN_LOCATE,   7'd0,  32'd5,       1, 0, 32'd0,   0, 0);
    add_row(FN_UNUSED_5, 7'd1,  32'd9,       1, 0, 32'd0,   0, 0);
    add_row(FN_INSERT,   7'd1,  VAL_MAX,     1, 1, 32'd0,   0, 1);
    add_row(FN_INSERT,   7'd1,  VAL_MIN,     1, 1, 32'd0,   0, 2);
    add_row(FN_READ,     7'd1,  32'd0,       1, 1, VAL_MIN, 0, 2);
    add_row(FN_READ,     7'd2,  32'd0,       1, 1, VAL_MAX, 0, 2);
    add_row(FN_READ,     7'd3,  32'd0,       1, 0, 32'd0,   0, 2);
    add_row(FN_DELETE,   7'd3,  32'd0,       1, 0, 32'd0,   0, 2);
    add_row(FN_SORTED,   7'd0,  32'd0,       1, 1, 32'd0,   2, 3);
    add_row(FN_SORTED,   7'd0,  VAL_MIN,     1, 1, 32'd0,   1, 4);
    add_row(FN_LOCATE,   7'd0,  32'd0,       1, 1, 32'd0,   3, 4);
    add_row(FN_LOCATE,   7'd0,  VAL_MAX,     1, 1, 32'd0,   4, 4);
    add_row(FN_LOCATE,   7'd0,  32'd12345,   1, 0, 32'd0,   0, 4);
    add_row(FN_UNUSED_6, 7'd2,  VAL_MAX,     1, 0, 32'd0,   0, 4);
    add_row(FN_UNUSED_7, 7'd65, 32'hffff_ffff, 1, 0, 32'd0, 0, 4);
    add_row(FN_DELETE,   7'd4,  32'd0,       1, 1, VAL_MAX, 0, 3);
    add_row(FN_DELETE,   7'd1,  32'd0,       1, 1, VAL_MIN, 0, 2);
    add_row(FN_INSERT,   7'd3,  32'hffff_ffff, 0, 0, 32'd0, 0, 0);
    add_row(FN_SORTED,   7'd0,  VAL_MAX,     0, 0, 32'd0,   0, 0);
    add_row(FN_INSERT,   7'd65, 32'd1,       1, 0, 32'd0,   0, 4);
    add_row(FN_READ,     7'd64, 32'd0,       1, 0, 32'd0,   0, 4);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[n]) send_request(script[n].fn, script[n].pos, script[n].val,
                                     script[n].typed, script[n].want);

    for (i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 79) == 0) quiet = ~quiet;
      if (i == 250 || i == 550) begin
        // hold off until the engine has answered everything
        in_tvalid <= 1'b0;
        while (list_results_q.size() != 0) @(posedge clk);
      end
      send_random();
    end
    in_tvalid <= 1'b0;

    while (list_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d results: insert %0d, delete %0d, read %0d, locate %0d, sorted %0d",
             checked, op_count[FN_INSERT], op_count[FN_DELETE], op_count[FN_READ],
             op_count[FN_LOCATE], op_count[FN_SORTED]);
    $display("unused codes %0d; list filled %0d times, emptied %0d times, %0d inserts refused",
             op_count[FN_UNUSED_5] + op_count[FN_UNUSED_6] + op_count[FN_UNUSED_7],
             times_full, times_emptied, full_rejects);
    if (errors == 0 && list_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sle_pkg.sv
sv/sequential_list_engine_top.sv
test/tb_sequential_list_engine_top.sv
